[hw/rtl/gtd_pkg.sv]
// Package for the Goertzel tone detector: sequencer codes, register
// indexes, field widths and the request bundle of the serial multiplier.
// No dependencies.
`timescale 1ns / 1ps

package gtd_pkg;

    // Field and state widths
    localparam int SAMPLE_W   = 16;
    localparam int RECUR_W    = 32;
    localparam int POWER_W    = 64;
    localparam int COUNT_W    = 16;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Serial multiplier: one multiplier bit per step
    localparam int MUL_STEPS  = 32;
    localparam int MUL_CNT_W  = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEFFICIENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_SHIFT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_SHIFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_SHIFT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_SHIFT    = 3'd5;

    // Register values after reset
    localparam logic [COUNT_W-1:0] WINDOW_RESET    = 16'd256;
    localparam logic [SHIFT_W-1:0] ON_SHIFT_RESET   = 5'd3;
    localparam logic [SHIFT_W-1:0] OFF_SHIFT_RESET  = 5'd1;
    localparam logic [SHIFT_W-1:0] RISE_SHIFT_RESET = 5'd6;
    localparam logic [SHIFT_W-1:0] FALL_SHIFT_RESET = 5'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_SEED,
        ST_TRACK,
        ST_STEP,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // Multiplications issued by the sequencer
    typedef enum logic [2:0] {
        OP_RECUR,
        OP_SCALE,
        OP_SQ1,
        OP_SQ2,
        OP_CROSS
    } mul_op_t;

    // Request to the serial multiplier
    typedef struct packed {
        logic               start;
        logic [RECUR_W-1:0] mcand;
        logic [RECUR_W-1:0] mplier;
    } mul_req_t;

endpackage

[hw/rtl/goertzel_cw_tone_detector_unit.sv]
// Goertzel tone detector top level: recurrence, power, noise floor and
// hysteresis sequencer. Depends on gtd_pkg and gtd_mul.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel s_valid/s_ready/s_sample carries signed 16-bit samples.
//   Result channel m_valid/m_ready carries m_tone, m_power, m_noise_floor,
//   one transfer per completed window.
//   Configuration: write cfg_wdata to register cfg_index while cfg_wr_en is
//   high; write only while the block is idle.
// Sample flow:
//   Every multiplication runs through one bit-serial multiplier, one bit
//   per cycle over 32 bits. s_ready is low from a sample's transfer until
//   its recurrence product is done, so samples are not overlapped. A
//   sample that closes a window adds four more multiplications and the
//   floor and hysteresis steps before the result register loads and
//   s_ready rises again.
// Reset:
//   aresetn (synchronous, active low) clears the recurrence, sample count,
//   noise floor and tone flag and restores the register defaults.
// Stall:
//   A result waits in the output register while m_ready is low; samples
//   keep being taken. Only when another window closes with the register
//   still full does the sequencer hold until the transfer.

module goertzel_cw_tone_detector_unit #(
    parameter int FRAC_BITS = 13
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [gtd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gtd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [gtd_pkg::SAMPLE_W-1:0]   s_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_tone,
    output logic signed [gtd_pkg::POWER_W-1:0]    m_power,
    output logic signed [gtd_pkg::POWER_W-1:0]    m_noise_floor
);

    localparam int RW = gtd_pkg::RECUR_W;
    localparam int PW = gtd_pkg::POWER_W;
    localparam int SW = gtd_pkg::SAMPLE_W;
    localparam int CW = gtd_pkg::COUNT_W;

    // Configuration registers
    logic [gtd_pkg::CFG_DATA_W-1:0] coef_reg;
    logic [CW-1:0]                  window_reg;
    logic [gtd_pkg::SHIFT_W-1:0]    on_shift_reg;
    logic [gtd_pkg::SHIFT_W-1:0]    off_shift_reg;
    logic [gtd_pkg::SHIFT_W-1:0]    rise_shift_reg;
    logic [gtd_pkg::SHIFT_W-1:0]    fall_shift_reg;

    // Sequencer
    gtd_pkg::state_t  state_reg, state_next;
    gtd_pkg::mul_op_t op_reg;

    // Datapath state
    logic [SW-1:0] x_reg;
    logic [RW-1:0] prev_reg;
    logic [RW-1:0] prev2_reg;
    logic [RW-1:0] m2_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] pacc_reg;
    logic [PW-1:0] floor_reg;
    logic [PW-1:0] diff_reg;
    logic          tone_reg;

    // Output register
    logic          m_valid_reg;
    logic          m_tone_reg;
    logic [PW-1:0] m_power_reg;
    logic [PW-1:0] m_floor_reg;

    // Multiplier interface
    gtd_pkg::mul_req_t mul_req;
    logic              mul_done;
    logic [PW-1:0]     mul_product;

    // Combinational datapath
    logic [RW-1:0]               scaled_w;
    logic [RW-1:0]               recur_sum;
    logic [CW:0]                 count_inc;
    logic                        win_done;
    logic [gtd_pkg::SHIFT_W-1:0] step_shift;
    logic [PW-1:0]               floor_step;
    logic                        floor_pos;
    logic [PW-1:0]               ref_level;
    logic [PW-1:0]               threshold;
    logic                        tone_hit;
    logic                        emit_free;
    logic                        in_xfer;

    gtd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_product)
    );

    // Recurrence, window count, floor and threshold arithmetic
    always_comb begin
        scaled_w   = mul_product[FRAC_BITS+RW-1:FRAC_BITS];
        recur_sum  = {{(RW - SW){x_reg[SW-1]}}, x_reg} + scaled_w - prev2_reg;
        count_inc  = {1'b0, count_reg} + 1'b1;
        win_done   = (count_inc >= {1'b0, window_reg});
        step_shift = diff_reg[PW-1] ? fall_shift_reg : rise_shift_reg;
        floor_step = floor_reg + PW'($signed(diff_reg) >>> step_shift);
        floor_pos  = !floor_reg[PW-1] && (|floor_reg);
        ref_level  = floor_pos ? floor_reg : PW'(1);
        threshold  = ref_level << (tone_reg ? off_shift_reg : on_shift_reg);
        tone_hit   = tone_reg ? ($signed(threshold) >= $signed(pacc_reg))
                              : ($signed(pacc_reg) >= $signed(threshold));
        emit_free  = !m_valid_reg || m_ready;
        in_xfer    = s_valid && s_ready;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gtd_pkg::ST_IDLE: begin
                if (s_valid) state_next = gtd_pkg::ST_MUL_GO;
            end
            gtd_pkg::ST_MUL_GO: begin
                state_next = gtd_pkg::ST_MUL_WAIT;
            end
            gtd_pkg::ST_MUL_WAIT: begin
                if (mul_done) begin
                    case (op_reg)
                        gtd_pkg::OP_RECUR:
                            state_next = win_done ? gtd_pkg::ST_MUL_GO : gtd_pkg::ST_IDLE;
                        gtd_pkg::OP_CROSS: state_next = gtd_pkg::ST_SEED;
                        default:           state_next = gtd_pkg::ST_MUL_GO;
                    endcase
                end
            end
            gtd_pkg::ST_SEED:   state_next = gtd_pkg::ST_TRACK;
            gtd_pkg::ST_TRACK:  state_next = gtd_pkg::ST_STEP;
            gtd_pkg::ST_STEP:   state_next = gtd_pkg::ST_DECIDE;
            gtd_pkg::ST_DECIDE: state_next = gtd_pkg::ST_EMIT;
            gtd_pkg::ST_EMIT: begin
                if (emit_free) state_next = gtd_pkg::ST_IDLE;
            end
            default: state_next = gtd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: input ready and multiplier operands
    always_comb begin
        s_ready        = (state_reg == gtd_pkg::ST_IDLE);
        mul_req.start  = (state_reg == gtd_pkg::ST_MUL_GO);
        mul_req.mcand  = prev_reg;
        mul_req.mplier = {{(RW - gtd_pkg::CFG_DATA_W){coef_reg[gtd_pkg::CFG_DATA_W-1]}},
                          coef_reg};
        case (op_reg)
            gtd_pkg::OP_SQ1: begin
                mul_req.mplier = prev_reg;
            end
            gtd_pkg::OP_SQ2: begin
                mul_req.mcand  = prev2_reg;
                mul_req.mplier = prev2_reg;
            end
            gtd_pkg::OP_CROSS: begin
                mul_req.mcand  = m2_reg;
                mul_req.mplier = prev2_reg;
            end
            default: ;
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg       <= '0;
            window_reg     <= gtd_pkg::WINDOW_RESET;
            on_shift_reg   <= gtd_pkg::ON_SHIFT_RESET;
            off_shift_reg  <= gtd_pkg::OFF_SHIFT_RESET;
            rise_shift_reg <= gtd_pkg::RISE_SHIFT_RESET;
            fall_shift_reg <= gtd_pkg::FALL_SHIFT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gtd_pkg::REG_COEFFICIENT:   coef_reg       <= cfg_wdata;
                gtd_pkg::REG_WINDOW_LENGTH: window_reg     <= cfg_wdata[CW-1:0];
                gtd_pkg::REG_ON_SHIFT:      on_shift_reg   <= cfg_wdata[gtd_pkg::SHIFT_W-1:0];
                gtd_pkg::REG_OFF_SHIFT:     off_shift_reg  <= cfg_wdata[gtd_pkg::SHIFT_W-1:0];
                gtd_pkg::REG_RISE_SHIFT:    rise_shift_reg <= cfg_wdata[gtd_pkg::SHIFT_W-1:0];
                gtd_pkg::REG_FALL_SHIFT:    fall_shift_reg <= cfg_wdata[gtd_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state, recurrence, floor and tone
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gtd_pkg::ST_IDLE;
            op_reg    <= gtd_pkg::OP_RECUR;
            prev_reg  <= '0;
            prev2_reg <= '0;
            count_reg <= '0;
            floor_reg <= '0;
            tone_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_xfer) op_reg <= gtd_pkg::OP_RECUR;
            if (state_reg == gtd_pkg::ST_MUL_WAIT && mul_done) begin
                case (op_reg)
                    gtd_pkg::OP_RECUR: begin
                        prev2_reg <= prev_reg;
                        prev_reg  <= recur_sum;
                        if (win_done) op_reg <= gtd_pkg::OP_SCALE;
                        else count_reg <= count_inc[CW-1:0];
                    end
                    gtd_pkg::OP_SCALE: op_reg <= gtd_pkg::OP_SQ1;
                    gtd_pkg::OP_SQ1:   op_reg <= gtd_pkg::OP_SQ2;
                    gtd_pkg::OP_SQ2:   op_reg <= gtd_pkg::OP_CROSS;
                    gtd_pkg::OP_CROSS: begin
                        prev_reg  <= '0;
                        prev2_reg <= '0;
                        count_reg <= '0;
                    end
                    default: ;
                endcase
            end
            // Seed the floor when it is not positive
            if (state_reg == gtd_pkg::ST_SEED && !floor_pos) floor_reg <= pacc_reg;
            // Leak the floor toward the power while the tone is off
            if (state_reg == gtd_pkg::ST_STEP && !tone_reg) floor_reg <= floor_step;
            // Switch the flag with hysteresis, at most once per window
            if (state_reg == gtd_pkg::ST_DECIDE && tone_hit) tone_reg <= !tone_reg;
        end
    end

    // Payload registers: sample, scaled value, power and floor error
    always_ff @(posedge aclk) begin
        if (in_xfer) x_reg <= s_sample;
        if (state_reg == gtd_pkg::ST_MUL_WAIT && mul_done) begin
            case (op_reg)
                gtd_pkg::OP_SCALE: m2_reg   <= scaled_w;
                gtd_pkg::OP_SQ1:   pacc_reg <= mul_product;
                gtd_pkg::OP_SQ2:   pacc_reg <= pacc_reg + mul_product;
                gtd_pkg::OP_CROSS: pacc_reg <= pacc_reg - mul_product;
                default: ;
            endcase
        end
        if (state_reg == gtd_pkg::ST_TRACK) diff_reg <= pacc_reg - floor_reg;
    end

    // Output register: load when free, drop after transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == gtd_pkg::ST_EMIT && emit_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == gtd_pkg::ST_EMIT && emit_free) begin
            m_tone_reg  <= tone_reg;
            m_power_reg <= pacc_reg;
            m_floor_reg <= floor_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tone        = m_tone_reg;
    assign m_power       = m_power_reg;
    assign m_noise_floor = m_floor_reg;

    // A sample transfer always starts its recurrence product
    a_xfer_starts_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == gtd_pkg::ST_MUL_GO && op_reg == gtd_pkg::OP_RECUR))
        else $error("sample transfer did not start the recurrence");

    // Multiplier completions arrive only while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == gtd_pkg::ST_MUL_WAIT))
        else $error("multiplier completion outside wait state");

    // The recurrence and count are clear once the power is formed
    a_window_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gtd_pkg::ST_SEED) |->
            (prev_reg == '0 && prev2_reg == '0 && count_reg == '0))
        else $error("recurrence not cleared at window end");

    // A full output register holds the sequencer until the transfer
    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gtd_pkg::ST_EMIT && m_valid_reg && !m_ready) |=>
            (state_reg == gtd_pkg::ST_EMIT && m_valid_reg))
        else $error("result overwritten before transfer");

endmodule

[hw/rtl/gtd_mul.sv]
// Bit-serial signed 32 x 32 multiplier, one multiplier bit per cycle.
// Depends on gtd_pkg.
`timescale 1ns / 1ps

module gtd_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gtd_pkg::mul_req_t              req,
    output logic                           done,
    output logic [gtd_pkg::POWER_W-1:0]    product
);

    logic [gtd_pkg::POWER_W-1:0]   mcand_reg;
    logic [gtd_pkg::RECUR_W-1:0]   mplier_reg;
    logic [gtd_pkg::POWER_W-1:0]   acc_reg;
    logic [gtd_pkg::POWER_W-1:0]   acc_next;
    logic [gtd_pkg::POWER_W-1:0]   partial;
    logic [gtd_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                          run_reg;
    logic                          done_reg;
    logic                          last_step;

    // Add the shifted multiplicand per set bit; the sign bit weighs negative
    always_comb begin
        last_step = (cnt_reg == gtd_pkg::MUL_CNT_W'(gtd_pkg::MUL_STEPS - 1));
        partial   = mplier_reg[0] ? mcand_reg : '0;
        acc_next  = last_step ? (acc_reg - partial) : (acc_reg + partial);
    end

    // Step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand shift registers and accumulator
    always_ff @(posedge aclk) begin
        if (req.start) begin
            mcand_reg  <= {{(gtd_pkg::POWER_W - gtd_pkg::RECUR_W){req.mcand[gtd_pkg::RECUR_W-1]}},
                           req.mcand};
            mplier_reg <= req.mplier;
            acc_reg    <= '0;
        end else if (run_reg) begin
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            acc_reg    <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

    // A new product is never requested while one is in progress
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !run_reg)
        else $error("multiplier restarted while running");

    // Completion follows the last step
    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg && last_step && !req.start) |=> (done_reg && !run_reg))
        else $error("multiplier completion missing");

    // Completion and stepping never overlap
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !run_reg)
        else $error("multiplier done while running");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for goertzel_cw_tone_detector_unit: a window tracker class
// predicts tone, power and noise floor per closed window and checks the result channel.
// Depends on gtd_pkg and the detector RTL.

module testbench;

    localparam int FRAC_BITS      = 13;
    localparam int SETTLE_CYCLES  = 250;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int SAMPLE_TARGET  = 750;

    // Indexes past the register list; writes there must be ignored
    localparam logic [gtd_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [gtd_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        logic                               tone;
        logic signed [gtd_pkg::POWER_W-1:0] power;
        logic signed [gtd_pkg::POWER_W-1:0] noise_floor;
    } window_result_t;

    // Tracks recurrence, floor and tone state; queues the result of each closed window
    class tone_window_tracker;
        logic signed [gtd_pkg::CFG_DATA_W-1:0] coef;
        logic [gtd_pkg::COUNT_W-1:0]           win_len;
        logic [gtd_pkg::SHIFT_W-1:0]           on_sh;
        logic [gtd_pkg::SHIFT_W-1:0]           off_sh;
        logic [gtd_pkg::SHIFT_W-1:0]           rise_sh;
        logic [gtd_pkg::SHIFT_W-1:0]           fall_sh;
        int                                    s1;
        int                                    s2;
        logic [gtd_pkg::COUNT_W-1:0]           count;
        longint                                floor_lvl;
        bit                                    tone;
        window_result_t                        closed_windows[$];
        int                                    mismatches;

        function new();
            coef       = '0;
            win_len    = gtd_pkg::WINDOW_RESET;
            on_sh      = gtd_pkg::ON_SHIFT_RESET;
            off_sh     = gtd_pkg::OFF_SHIFT_RESET;
            rise_sh    = gtd_pkg::RISE_SHIFT_RESET;
            fall_sh    = gtd_pkg::FALL_SHIFT_RESET;
            s1         = 0;
            s2         = 0;
            count      = '0;
            floor_lvl  = 0;
            tone       = 1'b0;
            mismatches = 0;
        endfunction

        function void set_register(logic [gtd_pkg::CFG_IDX_W-1:0] idx,
                                   logic [gtd_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                gtd_pkg::REG_COEFFICIENT:   coef    = val;
                gtd_pkg::REG_WINDOW_LENGTH: win_len = val;
                gtd_pkg::REG_ON_SHIFT:      on_sh   = val[gtd_pkg::SHIFT_W-1:0];
                gtd_pkg::REG_OFF_SHIFT:     off_sh  = val[gtd_pkg::SHIFT_W-1:0];
                gtd_pkg::REG_RISE_SHIFT:    rise_sh = val[gtd_pkg::SHIFT_W-1:0];
                gtd_pkg::REG_FALL_SHIFT:    fall_sh = val[gtd_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        // Coefficient times s, arithmetic shift by the fraction bits, cut to 32 bits
        function int scaled(int s);
            longint prod;
            prod = longint'(coef) * longint'(s);
            return int'(prod >>> FRAC_BITS);
        endfunction

        function void take_sample(logic signed [gtd_pkg::SAMPLE_W-1:0] x);
            int                        s0;
            logic [gtd_pkg::COUNT_W:0] next;
            longint                    p;
            longint                    diff;
            longint                    ref_lvl;
            window_result_t            r;
            // advance the recurrence, wrapping at 32 bits
            s0 = int'(x) + scaled(s1) - s2;
            s2 = s1;
            s1 = s0;
            next = {1'b0, count} + 1'b1;
            if (next < {1'b0, win_len}) begin
                count = next[gtd_pkg::COUNT_W-1:0];
                return;
            end
            // close the window; 64-bit products and sum wrap
            p = longint'(s1) * longint'(s1) + longint'(s2) * longint'(s2)
                - longint'(scaled(s1)) * longint'(s2);
            s1    = 0;
            s2    = 0;
            count = '0;
            // seed a floor that is not positive
            if (floor_lvl <= 0) floor_lvl = p;
            // leaky floor: slow rise, fast fall, only while the tone is off
            if (!tone) begin
                diff = p - floor_lvl;
                if (diff < 0) floor_lvl += diff >>> fall_sh;
                else floor_lvl += diff >>> rise_sh;
            end
            // hysteresis, at most one switch per window
            ref_lvl = (floor_lvl > 0) ? floor_lvl : 64'sd1;
            if (!tone) begin
                if (p >= (ref_lvl << on_sh)) tone = 1'b1;
            end else if ((ref_lvl << off_sh) >= p) begin
                tone = 1'b0;
            end
            r.tone        = tone;
            r.power       = p;
            r.noise_floor = floor_lvl;
            closed_windows.push_back(r);
        endfunction

        function void match_window(logic t, logic signed [gtd_pkg::POWER_W-1:0] pw,
                                   logic signed [gtd_pkg::POWER_W-1:0] fl);
            window_result_t r;
            if (closed_windows.size() == 0) begin
                $error("result with no window pending: tone %0b power %0d noise_floor %0d",
                       t, pw, fl);
                mismatches++;
                return;
            end
            r = closed_windows.pop_front();
            if (t !== r.tone) begin
                $error("tone: expected %0b, got %0b", r.tone, t);
                mismatches++;
            end
            if (pw !== r.power) begin
                $error("power: expected %0d, got %0d", r.power, pw);
                mismatches++;
            end
            if (fl !== r.noise_floor) begin
                $error("noise_floor: expected %0d, got %0d", r.noise_floor, fl);
                mismatches++;
            end
        endfunction
    endclass

    logic                                aclk;
    logic                                aresetn   = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [gtd_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [gtd_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    logic signed [gtd_pkg::SAMPLE_W-1:0] s_sample  = '0;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    logic                                m_tone;
    logic signed [gtd_pkg::POWER_W-1:0]  m_power;
    logic signed [gtd_pkg::POWER_W-1:0]  m_noise_floor;

    int samples_sent = 0;
    int rx_hold_len  = 0;
    int stall_cycles = 0;

    tone_window_tracker tracker = new();

    goertzel_cw_tone_detector_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tone       (m_tone),
        .m_power      (m_power),
        .m_noise_floor(m_noise_floor)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    task automatic write_reg(input logic [gtd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gtd_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        tracker.set_register(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one sample after an optional gap and hold it until the transfer
    task automatic send_sample(input logic signed [gtd_pkg::SAMPLE_W-1:0] v, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
        tracker.take_sample(v);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic pause_for_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (tracker.closed_windows.size() != 0);
    endtask

    // Drain results, then let a sample still in flight finish before any write
    task automatic quiesce();
        pause_for_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Result side: random ready with long open stretches and requested hold-offs
    initial begin : result_sink
        int span;
        forever begin
            if (rx_hold_len > 0) begin
                span        = rx_hold_len;
                rx_hold_len = 0;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 9) < 6) begin
                m_ready <= 1'b1;
                span = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 12);
            end else begin
                m_ready <= 1'b0;
                span = idle_gap() + 1;
            end
            repeat (span) @(negedge aclk);
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.match_window(m_tone, m_power, m_noise_floor);
    end

    // Abort when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        logic [gtd_pkg::CFG_IDX_W-1:0]       shift_regs[4];
        logic signed [gtd_pkg::SAMPLE_W-1:0] smp;
        logic [gtd_pkg::CFG_DATA_W-1:0]      coef_val;
        logic [gtd_pkg::COUNT_W-1:0]         wlen;
        logic [gtd_pkg::SHIFT_W-1:0]         sh;
        int                                  r;
        int                                  n;
        int                                  i;
        int                                  phase;
        int                                  chunk_left;
        int                                  lvl;
        bit                                  burst_mode;
        bit                                  no_gaps;

        shift_regs = '{gtd_pkg::REG_ON_SHIFT, gtd_pkg::REG_OFF_SHIFT,
                       gtd_pkg::REG_RISE_SHIFT, gtd_pkg::REG_FALL_SHIFT};
        phase      = 0;
        chunk_left = 0;
        lvl        = 0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: a partial window of extreme samples
        send_sample(16'sh7FFF, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh0000, 1);
        send_sample(16'shFFFF, 0);
        quiesce();

        // Window lowered below the count, all shifts zero
        write_reg(gtd_pkg::REG_WINDOW_LENGTH, 16'd2);
        write_reg(gtd_pkg::REG_COEFFICIENT, 16'h4000);
        write_reg(gtd_pkg::REG_ON_SHIFT, 16'd0);
        write_reg(gtd_pkg::REG_OFF_SHIFT, 16'd0);
        write_reg(gtd_pkg::REG_RISE_SHIFT, 16'd0);
        write_reg(gtd_pkg::REG_FALL_SHIFT, 16'd0);
        send_sample(16'sh7FFF, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh7FFF, 2);
        send_sample(16'sh0001, 0);
        quiesce();

        // Window length zero closes on every sample; all shifts at the top
        write_reg(gtd_pkg::REG_WINDOW_LENGTH, 16'd0);
        write_reg(gtd_pkg::REG_COEFFICIENT, 16'hC000);
        write_reg(gtd_pkg::REG_ON_SHIFT, 16'd31);
        write_reg(gtd_pkg::REG_OFF_SHIFT, 16'd31);
        write_reg(gtd_pkg::REG_RISE_SHIFT, 16'd31);
        write_reg(gtd_pkg::REG_FALL_SHIFT, 16'd31);
        send_sample(16'sh0001, 0);
        send_sample(16'shFFFF, 0);
        send_sample(16'sh7FFF, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh0000, 0);
        quiesce();

        // Longest window, coefficient at the top, writes past the register list
        write_reg(gtd_pkg::REG_WINDOW_LENGTH, 16'hFFFF);
        write_reg(gtd_pkg::REG_COEFFICIENT, 16'h7FFF);
        write_reg(REG_SPARE_6, 16'hFFFF);
        write_reg(REG_SPARE_7, 16'hFFFF);
        send_sample(16'sh7FFF, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh5555, 0);
        send_sample(16'shAAAA, 0);
        quiesce();

        // Shorten the long window mid-way; coefficient at the bottom, loud, silence, loud
        write_reg(gtd_pkg::REG_WINDOW_LENGTH, 16'd1);
        write_reg(gtd_pkg::REG_COEFFICIENT, 16'h8000);
        write_reg(gtd_pkg::REG_ON_SHIFT, 16'd3);
        write_reg(gtd_pkg::REG_OFF_SHIFT, 16'd1);
        send_sample(16'sh7FFF, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh0000, 0);
        send_sample(16'sh0000, 0);
        send_sample(16'sh7FFF, 0);
        quiesce();

        // Random phases: new settings while idle, then bursts of loud and quiet samples
        while (samples_sent < SAMPLE_TARGET) begin
            burst_mode = (phase == 0) || ($urandom_range(0, 9) == 0);
            no_gaps    = burst_mode || ($urandom_range(0, 4) == 0);

            if ($urandom_range(0, 9) < 7) begin
                r = $urandom_range(0, 19);
                if (r == 0) coef_val = 16'h8000;
                else if (r == 1) coef_val = 16'h7FFF;
                else if (r == 2) coef_val = 16'hC000;
                else if (r == 3) coef_val = 16'h4000;
                else coef_val = 16'(int'($urandom_range(0, 32768)) - 16384);
                write_reg(gtd_pkg::REG_COEFFICIENT, coef_val);
            end

            r = $urandom_range(0, 19);
            if (burst_mode) wlen = 16'd1;
            else if (r == 0) wlen = 16'd0;
            else if (r < 16) wlen = 16'($urandom_range(1, 8));
            else wlen = 16'($urandom_range(9, 40));
            if (burst_mode || $urandom_range(0, 9) < 7)
                write_reg(gtd_pkg::REG_WINDOW_LENGTH, wlen);

            foreach (shift_regs[k]) begin
                if ($urandom_range(0, 9) < 6) begin
                    r = $urandom_range(0, 19);
                    if (r < 14) sh = 5'($urandom_range(0, 6));
                    else if (r < 17) sh = 5'($urandom);
                    else if (r == 17) sh = 5'd0;
                    else sh = 5'd31;
                    write_reg(shift_regs[k], {11'($urandom), sh});
                end
            end

            if ($urandom_range(0, 19) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_6 : REG_SPARE_7,
                          16'($urandom));

            // In a burst the sink holds off while samples keep coming
            n = burst_mode ? 30 : $urandom_range(15, 50);
            if (burst_mode) rx_hold_len = RX_HOLD_CYCLES;

            for (i = 0; i < n; i++) begin
                if (chunk_left == 0) begin
                    chunk_left = (tracker.win_len == 0) ? 1 : int'(tracker.win_len);
                    lvl = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(4, 15);
                end
                chunk_left--;
                smp = 16'($urandom);
                smp = smp >>> lvl;
                send_sample(smp, no_gaps ? 0 : idle_gap());
                if (!burst_mode && $urandom_range(0, 49) == 0) pause_for_results();
            end
            quiesce();
            phase++;
        end

        if (tracker.mismatches == 0 && tracker.closed_windows.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[goertzel_cw_tone_detector_unit.f]
hw/rtl/gtd_pkg.sv
hw/rtl/gtd_mul.sv
hw/rtl/goertzel_cw_tone_detector_unit.sv
bench/testbench.sv
